FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/udprx_pkg.sv
// types and constants of the udp receive port demultiplexer
package udprx_pkg;

    localparam int unsigned  BUFFER_BYTES = 2048;
    localparam logic [16:0]  BUFFER_LIMIT = 17'(BUFFER_BYTES);

    localparam int unsigned  RES_FIFO_DEPTH = 4;
    localparam int unsigned  RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int unsigned  RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

    localparam logic         KIND_FWD  = 1'b0;
    localparam logic         KIND_WORD = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_FORWARD = 2'd1,
        PH_BUFFER  = 2'd2,
        PH_DISCARD = 2'd3
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  fwd_byte;
        logic        fwd_last;
        logic [8:0]  word_index;
        logic [31:0] word_data;
        logic        release_res;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

FILE: hw/rtl/udprx_result_fifo.sv
// result queue taking up to two transactions per cycle while it has space and giving one when the reader is ready
module udprx_result_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  udprx_pkg::t_push     i_push,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output udprx_pkg::t_result   o_data
);

    udprx_pkg::t_result r_mem [udprx_pkg::RES_FIFO_DEPTH];

    logic [udprx_pkg::RES_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [udprx_pkg::RES_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [udprx_pkg::RES_CNT_W-1:0] r_count,  n_count;
    logic                            pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_space = (r_count <= udprx_pkg::RES_CNT_W'(udprx_pkg::RES_FIFO_DEPTH - 2));
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + udprx_pkg::RES_PTR_W'(i_push.num);
        n_rd_ptr = r_rd_ptr + udprx_pkg::RES_PTR_W'(pop);
        n_count  = r_count + udprx_pkg::RES_CNT_W'(i_push.num)
                 - udprx_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[udprx_pkg::RES_PTR_W'(r_wr_ptr + 1'b1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > udprx_pkg::RES_CNT_W'(udprx_pkg::RES_FIFO_DEPTH), "result queue overfilled")
    `ASSERT_NEVER(a_push_no_space, i_clk, i_rst_n, (i_push.num != 2'd0) && !o_space, "push without space")
    `ASSERT_CLK(a_double_push, i_clk, i_rst_n, (i_push.num == 2'd2 && !pop) |=> (r_count == $past(r_count) + 2'd2), "double push lost an entry")

endmodule

FILE: hw/rtl/udp_receive_port_demux_unit.sv
// top level of the udp receive port demultiplexer
// Takes one packet byte per clock (14-byte header: source address, udp
// length, udp header) and routes the payload as forwarded bytes, as 32-bit
// buffer word writes, or drops it. A byte is processed in the cycle it is
// accepted and its results land in a four-entry result queue, so a new byte
// is accepted every cycle while the queue holds at most two entries; the
// 14th header byte of a buffered packet yields two word writes, so the rate
// is one byte per clock whenever the consumer takes one result per clock.
module udp_receive_port_demux_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_buffer_granted,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_fwd_byte,
    output logic        o_fwd_last,
    output logic [8:0]  o_word_index,
    output logic [31:0] o_word_data,
    output logic        o_release_res
);

    localparam logic [3:0] HDR_LEN_HI   = 4'd4;
    localparam logic [3:0] HDR_LEN_LO   = 4'd5;
    localparam logic [3:0] HDR_SPORT_HI = 4'd6;
    localparam logic [3:0] HDR_SPORT_LO = 4'd7;
    localparam logic [3:0] HDR_DPORT_HI = 4'd8;
    localparam logic [3:0] HDR_DPORT_LO = 4'd9;
    localparam logic [3:0] HDR_LAST     = 4'd13;
    localparam logic       REG_LOCAL_PORT = 1'b0;

    logic [15:0]       r_local_port;
    udprx_pkg::t_phase r_phase, n_phase;
    logic [3:0]        r_hdr_cnt, n_hdr_cnt;
    logic [8:0]        r_next_word, n_next_word;
    logic [31:0]       r_source_addr, n_source_addr;
    logic [15:0]       r_source_port, n_source_port;
    logic [15:0]       r_dest_port, n_dest_port;
    logic [15:0]       r_udp_len, n_udp_len;
    logic [1:0]        r_lane_pos, n_lane_pos;
    logic [7:0]        r_lane [4];
    logic [7:0]        n_lane [4];

    logic               in_fire;
    logic               fifo_space;
    logic               hdr_done;
    logic               take_buffer;
    logic [15:0]        plen;
    udprx_pkg::t_push   push;
    udprx_pkg::t_result res_out;

    function automatic udprx_pkg::t_result make_word(input logic [8:0] idx,
                                                     input logic [31:0] data,
                                                     input logic rel);
        udprx_pkg::t_result r;
        r             = '0;
        r.kind        = udprx_pkg::KIND_WORD;
        r.word_index  = idx;
        r.word_data   = data;
        r.release_res = rel;
        return r;
    endfunction

    // apb register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOCAL_PORT) ? {16'h0000, r_local_port} : 32'h0000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_port <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_LOCAL_PORT) begin
            r_local_port <= pwdata[15:0];
        end
    end

    assign o_ready = fifo_space;
    assign in_fire = i_valid && o_ready;

    assign hdr_done    = (r_phase == udprx_pkg::PH_HEADER) && (r_hdr_cnt == HDR_LAST);
    assign plen        = r_udp_len - 16'd8;
    assign take_buffer = (r_dest_port == r_local_port) && i_buffer_granted
                      && (({1'b0, plen} + 17'd8) <= udprx_pkg::BUFFER_LIMIT);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (in_fire) begin
            if (i_last_byte) begin
                n_phase = udprx_pkg::PH_HEADER;
            end else if (hdr_done) begin
                if (r_dest_port != r_local_port) begin
                    n_phase = udprx_pkg::PH_FORWARD;
                end else if (take_buffer) begin
                    n_phase = udprx_pkg::PH_BUFFER;
                end else begin
                    n_phase = udprx_pkg::PH_DISCARD;
                end
            end
        end
    end

    // datapath and results
    always_comb begin
        n_hdr_cnt     = r_hdr_cnt;
        n_next_word   = r_next_word;
        n_source_addr = r_source_addr;
        n_source_port = r_source_port;
        n_dest_port   = r_dest_port;
        n_udp_len     = r_udp_len;
        n_lane_pos    = r_lane_pos;
        n_lane        = r_lane;
        push          = '0;
        if (in_fire) begin
            unique case (r_phase)
                udprx_pkg::PH_HEADER: begin
                    unique case (r_hdr_cnt)
                        4'd0, 4'd1, 4'd2, 4'd3:
                            n_source_addr[{r_hdr_cnt[1:0], 3'b000} +: 8] = i_data_byte;
                        HDR_LEN_HI:   n_udp_len[15:8]     = i_data_byte;
                        HDR_LEN_LO:   n_udp_len[7:0]      = i_data_byte;
                        HDR_SPORT_HI: n_source_port[15:8] = i_data_byte;
                        HDR_SPORT_LO: n_source_port[7:0]  = i_data_byte;
                        HDR_DPORT_HI: n_dest_port[15:8]   = i_data_byte;
                        HDR_DPORT_LO: n_dest_port[7:0]    = i_data_byte;
                        default: ;
                    endcase
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                    if (hdr_done && (r_dest_port == r_local_port) && take_buffer) begin
                        push.num    = 2'd2;
                        push.first  = make_word(r_next_word, r_source_addr, 1'b0);
                        push.second = make_word(r_next_word + 9'd1,
                                                {r_udp_len, r_source_port}, i_last_byte);
                        n_next_word = r_next_word + 9'd2;
                    end
                end
                udprx_pkg::PH_FORWARD: begin
                    push.num            = 2'd1;
                    push.first.kind     = udprx_pkg::KIND_FWD;
                    push.first.fwd_byte = i_data_byte;
                    push.first.fwd_last = i_last_byte;
                end
                udprx_pkg::PH_BUFFER: begin
                    n_lane[r_lane_pos] = i_data_byte;
                    if (r_lane_pos == 2'd3 || i_last_byte) begin
                        push.num    = 2'd1;
                        push.first  = make_word(r_next_word,
                                                {n_lane[3], n_lane[2], n_lane[1], n_lane[0]},
                                                i_last_byte);
                        n_next_word = r_next_word + 9'd1;
                    end
                    n_lane_pos = r_lane_pos + 2'd1;
                end
                udprx_pkg::PH_DISCARD: ;
            endcase
            if (i_last_byte) begin
                n_hdr_cnt   = '0;
                n_next_word = '0;
                n_lane_pos  = '0;
                n_lane      = '{default: 8'h00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= udprx_pkg::PH_HEADER;
            r_hdr_cnt     <= '0;
            r_next_word   <= '0;
            r_source_addr <= '0;
            r_source_port <= '0;
            r_dest_port   <= '0;
            r_udp_len     <= '0;
            r_lane_pos    <= '0;
            r_lane        <= '{default: 8'h00};
        end else begin
            r_phase       <= n_phase;
            r_hdr_cnt     <= n_hdr_cnt;
            r_next_word   <= n_next_word;
            r_source_addr <= n_source_addr;
            r_source_port <= n_source_port;
            r_dest_port   <= n_dest_port;
            r_udp_len     <= n_udp_len;
            r_lane_pos    <= n_lane_pos;
            r_lane        <= n_lane;
        end
    end

    udprx_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (fifo_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (res_out)
    );

    assign o_kind        = res_out.kind;
    assign o_fwd_byte    = res_out.fwd_byte;
    assign o_fwd_last    = res_out.fwd_last;
    assign o_word_index  = res_out.word_index;
    assign o_word_data   = res_out.word_data;
    assign o_release_res = res_out.release_res;

`include "assert_macros.svh"

    `ASSERT_CLK(a_header_idle_lanes, i_clk, i_rst_n, (r_phase == udprx_pkg::PH_HEADER) |-> (r_lane_pos == 2'd0 && r_next_word == 9'd0), "lane or word counter left over in header")
    `ASSERT_CLK(a_forward_one, i_clk, i_rst_n, (in_fire && r_phase == udprx_pkg::PH_FORWARD) |-> (push.num == 2'd1), "forwarded byte not queued")
    `ASSERT_CLK(a_last_ends, i_clk, i_rst_n, (in_fire && i_last_byte) |=> (r_phase == udprx_pkg::PH_HEADER && r_hdr_cnt == 4'd0), "packet end did not return to header")

endmodule
